[rtl/irc_pkg.sv]
// Shared types, widths and codes for the insulation resistance classifier.
package irc_pkg;

  // Field widths
  localparam int CH_FIELD_W = 1;
  localparam int DEV_W      = 3;
  localparam int CODE_W     = 16;
  localparam int RATIO_W    = 26;
  localparam int LIMIT_W    = 20;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Serial divider sizing
  localparam int NUM_W     = RATIO_W;
  localparam int DEN_W     = 13;
  localparam int STEP_W    = $clog2(NUM_W + 1);
  localparam int BUS_STEPS = CODE_W;

  // Scaling constants
  localparam int unsigned OVERRANGE_VALUE = 600 * 1000;
  localparam int unsigned KOHM_SCALE      = 1000;
  localparam int unsigned DECI            = 10;

  localparam int CHANNELS_DEFAULT = 2;

  // Monitor device states
  localparam logic [DEV_W-1:0] DEV_INVALID  = 3'd0;
  localparam logic [DEV_W-1:0] DEV_CHECKING = 3'd1;
  localparam logic [DEV_W-1:0] DEV_VALID    = 3'd2;
  localparam logic [DEV_W-1:0] DEV_SELFTEST = 3'd3;

  // Channel status codes
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CHECKING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VALID    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FAULT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WARN     = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_CODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRANGE_CODE = 2'd3;

  localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST    = 20'd100;
  localparam logic [LIMIT_W-1:0] WARN_LIMIT_RST     = 20'd500;
  localparam logic [CODE_W-1:0]  INVALID_CODE_RST   = 16'd65535;
  localparam logic [CODE_W-1:0]  OVERRANGE_CODE_RST = 16'd65534;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [DEV_W-1:0]      device_state;
    logic [CODE_W-1:0]     pos_kohm;
    logic [CODE_W-1:0]     neg_kohm;
    logic [CODE_W-1:0]     bus_decivolt;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] channel_status;
    logic [RATIO_W-1:0]  pos_ohm_per_volt;
    logic [RATIO_W-1:0]  neg_ohm_per_volt;
    logic                pos_fault;
    logic                neg_fault;
    logic                pos_warn;
    logic                neg_warn;
    logic                selftest_fault;
  } out_item_t;

  typedef struct packed {
    logic selftest;
    logic neg_warn;
    logic pos_warn;
    logic neg_fault;
    logic pos_fault;
  } flags_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] fault_limit;
    logic [LIMIT_W-1:0] warn_limit;
    logic [CODE_W-1:0]  invalid_code;
    logic [CODE_W-1:0]  overrange_code;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/insulation_resistance_classifier_top.sv]
// Top level: report intake, divider sequencing, per-channel state and result register.
// Valid-state report: the shared bit-serial divider first forms bus/10, then the ratio
// of each pole over those volts, before the result is stored; no new report is taken
// until the current one is finished and the state is back to idle.
// Other device states: the result is stored without using the divider.
// A full output register stalls the update until the beat is taken.
// Synchronous reset clears channel status to invalid, all flags, and the registers to defaults.
module insulation_resistance_classifier_top #(
  parameter int CHANNELS = irc_pkg::CHANNELS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  irc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output irc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [irc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VOLT  = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_NEG   = 3'd3;
  localparam logic [2:0] S_CLASS = 3'd4;

  logic [2:0]         state_r, state_nxt;
  cfg_t               cfg_r;
  in_item_t           item_r;
  logic [DEN_W-1:0]   volts_r;
  logic [RATIO_W-1:0] pv_r, pv_nxt;
  logic [RATIO_W-1:0] nv_r, nv_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [STATUS_W-1:0] status_r [CHANNELS];
  flags_t              flags_r  [CHANNELS];

  logic            in_acc;
  logic            ch_ok;
  logic            out_free;
  logic            store_we;
  logic [CH_W-1:0] idx;

  div_cmd_t         div_cmd;
  div_sts_t         div_sts;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;

  logic                pos_bad, neg_bad;
  logic [STATUS_W-1:0] st_new;
  flags_t              fl_new;

  function automatic logic [RATIO_W-1:0] pole_value(
    input logic [CODE_W-1:0]  code,
    input logic [NUM_W-1:0]   quotient,
    input logic [DEN_W-1:0]   volts,
    input cfg_t               cfg
  );
    logic [RATIO_W-1:0] v;
    if (code == cfg.invalid_code) begin
      v = '0;
    end else if (code == cfg.overrange_code) begin
      v = RATIO_W'(OVERRANGE_VALUE);
    end else if (code == '0 || volts == '0) begin
      v = '0;
    end else begin
      v = quotient;
    end
    return v;
  endfunction

  function automatic logic [NUM_W-1:0] kohm_to_ohm(input logic [CODE_W-1:0] code);
    return NUM_W'(code) * NUM_W'(KOHM_SCALE);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ch_ok    = (int'(in_data.channel) < CHANNELS);
  assign out_free = !out_valid_r || out_ready;
  assign store_we = (state_r == S_CLASS) && out_free;
  assign idx      = CH_W'(item_r.channel);

  assign pos_bad = (item_r.pos_kohm == cfg_r.invalid_code);
  assign neg_bad = (item_r.neg_kohm == cfg_r.invalid_code);

  // divider launches: bus/10 at intake, then each pole over the captured volts
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.steps = STEP_W'(NUM_W);
    div_num       = kohm_to_ohm(item_r.pos_kohm);
    div_den       = volts_r;
    state_nxt     = state_r;
    pv_nxt        = pv_r;
    nv_nxt        = nv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && ch_ok) begin
          pv_nxt = '0;
          nv_nxt = '0;
          if (in_data.device_state == DEV_VALID) begin
            div_cmd.start = 1'b1;
            div_cmd.steps = STEP_W'(BUS_STEPS);
            div_num       = {in_data.bus_decivolt, {(NUM_W - CODE_W){1'b0}}};
            div_den       = DEN_W'(DECI);
            state_nxt     = S_VOLT;
          end else begin
            state_nxt = S_CLASS;
          end
        end
      end
      S_VOLT: begin
        if (div_sts.done) begin
          div_cmd.start = 1'b1;
          div_num       = kohm_to_ohm(item_r.pos_kohm);
          div_den       = div_quot[DEN_W-1:0];
          state_nxt     = S_POS;
        end
      end
      S_POS: begin
        if (div_sts.done) begin
          pv_nxt        = pole_value(item_r.pos_kohm, div_quot, volts_r, cfg_r);
          div_cmd.start = 1'b1;
          div_num       = kohm_to_ohm(item_r.neg_kohm);
          div_den       = volts_r;
          state_nxt     = S_NEG;
        end
      end
      S_NEG: begin
        if (div_sts.done) begin
          nv_nxt    = pole_value(item_r.neg_kohm, div_quot, volts_r, cfg_r);
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  irc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .num  (div_num),
    .den  (div_den),
    .sts  (div_sts),
    .quot (div_quot)
  );

  irc_class u_class (
    .dev_state(item_r.device_state),
    .pv       (pv_r),
    .nv       (nv_r),
    .pos_bad  (pos_bad),
    .neg_bad  (neg_bad),
    .cfg      (cfg_r),
    .st_old   (status_r[idx]),
    .fl_old   (flags_r[idx]),
    .st_new   (st_new),
    .fl_new   (fl_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r.fault_limit    <= FAULT_LIMIT_RST;
      cfg_r.warn_limit     <= WARN_LIMIT_RST;
      cfg_r.invalid_code   <= INVALID_CODE_RST;
      cfg_r.overrange_code <= OVERRANGE_CODE_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        status_r[i] <= ST_INVALID;
        flags_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (store_we) begin
        status_r[idx] <= st_new;
        flags_r[idx]  <= fl_new;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FAULT_LIMIT:    cfg_r.fault_limit    <= cfg_data[LIMIT_W-1:0];
          REG_WARN_LIMIT:     cfg_r.warn_limit     <= cfg_data[LIMIT_W-1:0];
          REG_INVALID_CODE:   cfg_r.invalid_code   <= cfg_data[CODE_W-1:0];
          REG_OVERRANGE_CODE: cfg_r.overrange_code <= cfg_data[CODE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
    if (div_sts.done && state_r == S_VOLT) volts_r <= div_quot[DEN_W-1:0];
    pv_r <= pv_nxt;
    nv_r <= nv_nxt;
    if (store_we) begin
      out_data_r.channel_status   <= st_new;
      out_data_r.pos_ohm_per_volt <= pv_r;
      out_data_r.neg_ohm_per_volt <= nv_r;
      out_data_r.pos_fault        <= fl_new.pos_fault;
      out_data_r.neg_fault        <= fl_new.neg_fault;
      out_data_r.pos_warn         <= fl_new.pos_warn;
      out_data_r.neg_warn         <= fl_new.neg_warn;
      out_data_r.selftest_fault   <= fl_new.selftest;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // intake only with the divider parked
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_sts.busy)
    else $error("report taken while divider busy");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_VOLT || state_r == S_POS || state_r == S_NEG))
    else $error("divider finished outside a divide state");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |=> out_valid && state_r == S_IDLE)
    else $error("channel update without a result beat");

  a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLASS && item_r.device_state != DEV_VALID) |-> (pv_r == '0 && nv_r == '0))
    else $error("ratio left over from an earlier report");

  for (genvar g = 0; g < CHANNELS; g++) begin : g_sticky
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
      (flags_r[g].pos_fault && flags_r[g].neg_fault && flags_r[g].selftest)
        |=> (flags_r[g].pos_fault && flags_r[g].neg_fault && flags_r[g].selftest))
      else $error("sticky flag cleared");
  end

endmodule

[rtl/irc_div.sv]
// Restoring divider, one quotient bit per cycle, numerator fed MSB first.
module irc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  irc_pkg::div_cmd_t          cmd,
  input  logic [irc_pkg::NUM_W-1:0]  num,
  input  logic [irc_pkg::DEN_W-1:0]  den,
  output irc_pkg::div_sts_t          sts,
  output logic [irc_pkg::NUM_W-1:0]  quot
);
  import irc_pkg::*;

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_diff;
  logic           take;

  assign rem_sh   = {rem_r, num_r[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign take     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt  = take ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_nxt = {quot_r[NUM_W-2:0], take};
      cnt_nxt  = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quot_r;

endmodule

[rtl/irc_class.sv]
// Next channel status and flags from the device state and the two pole ratios.
module irc_class (
  input  logic [irc_pkg::DEV_W-1:0]    dev_state,
  input  logic [irc_pkg::RATIO_W-1:0]  pv,
  input  logic [irc_pkg::RATIO_W-1:0]  nv,
  input  logic                         pos_bad,
  input  logic                         neg_bad,
  input  irc_pkg::cfg_t                cfg,
  input  logic [irc_pkg::STATUS_W-1:0] st_old,
  input  irc_pkg::flags_t              fl_old,
  output logic [irc_pkg::STATUS_W-1:0] st_new,
  output irc_pkg::flags_t              fl_new
);
  import irc_pkg::*;

  logic [RATIO_W-1:0] fault_lim;
  logic [RATIO_W-1:0] warn_lim;

  assign fault_lim = RATIO_W'(cfg.fault_limit);
  assign warn_lim  = RATIO_W'(cfg.warn_limit);

  always_comb begin
    st_new = st_old;
    fl_new = fl_old;
    case (dev_state)
      DEV_INVALID:  st_new = ST_INVALID;
      DEV_CHECKING: st_new = ST_CHECKING;
      DEV_VALID: begin
        if (pos_bad) begin
          st_new           = ST_FAULT;
          fl_new.pos_fault = 1'b1;
        end
        if (neg_bad) begin
          st_new           = ST_FAULT;
          fl_new.neg_fault = 1'b1;
        end
        // warning drops on first fault latch, or with both poles >= warn limit
        if (pv < fault_lim) begin
          st_new = ST_FAULT;
          if (!fl_new.pos_fault) begin
            fl_new.pos_fault = 1'b1;
            fl_new.pos_warn  = 1'b0;
          end
        end else if (pv < warn_lim) begin
          st_new          = ST_WARN;
          fl_new.pos_warn = 1'b1;
        end
        if (nv < fault_lim) begin
          st_new = ST_FAULT;
          if (!fl_new.neg_fault) begin
            fl_new.neg_fault = 1'b1;
            fl_new.neg_warn  = 1'b0;
          end
        end else if (nv < warn_lim) begin
          st_new          = ST_WARN;
          fl_new.neg_warn = 1'b1;
        end
        if (pv >= warn_lim && nv >= warn_lim) begin
          st_new          = ST_VALID;
          fl_new.pos_warn = 1'b0;
          fl_new.neg_warn = 1'b0;
        end
      end
      DEV_SELFTEST: begin
        st_new          = ST_FAULT;
        fl_new.selftest = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
